FILE: hdl/ufb_pkg.sv
// Shared types and constants for the UDP/IPv4 frame builder.
package ufb_pkg;

   // Frame layout
   localparam int HDR_BYTES      = 42;
   localparam int HDR_IDX_W      = $clog2(HDR_BYTES);
   localparam int LEN_W          = 16;
   localparam int CSUM_W         = 16;

   localparam logic [LEN_W-1:0] MAX_PAYLOAD     = 16'd65507;
   localparam logic [LEN_W-1:0] IP_OVERHEAD     = 16'd28;
   localparam logic [LEN_W-1:0] UDP_OVERHEAD    = 16'd8;

   localparam logic [7:0]  BCAST_BYTE     = 8'hFF;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IP_VER_IHL     = 8'h45;
   localparam logic [15:0] IP_FLAGS_DF    = 16'h4000;
   localparam logic [7:0]  IP_TTL         = 8'd64;
   localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;
   localparam int MAC_W      = 48;
   localparam int IP_W       = 32;
   localparam int PORT_W     = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_MAC   = 3'd0,
      CSR_SRC_IP    = 3'd1,
      CSR_DEST_IP   = 3'd2,
      CSR_SPORT     = 3'd3,
      CSR_DPORT     = 3'd4
   } csr_idx_type;

   // Request opcodes
   typedef enum logic {
      OP_START = 1'b0,
      OP_DATA  = 1'b1
   } op_type;

   // Configured addressing fields, handed to the header mux and checksum
   typedef struct packed {
      logic [MAC_W-1:0]  src_mac;
      logic [IP_W-1:0]   src_ip;
      logic [IP_W-1:0]   dest_ip;
      logic [PORT_W-1:0] sport;
      logic [PORT_W-1:0] dport;
   } addr_cfg_type;

endpackage

FILE: hdl/ufb_req_if.sv
// Request channel: start-frame and payload-byte requests.
interface ufb_req_if import ufb_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             op;
   logic [LEN_W-1:0] data_len;
   logic [7:0]       payload_byte;

   modport source (output valid, output op, output data_len, output payload_byte,
                   input ready);
   modport sink   (input valid, input op, input data_len, input payload_byte,
                   output ready);
endinterface

FILE: hdl/ufb_rsp_if.sv
// Response channel: one frame byte per handshake.
interface ufb_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       end_of_frame;
   logic       overrun;

   modport source (output valid, output out_byte, output end_of_frame, output overrun,
                   input ready);
   modport sink   (input valid, input out_byte, input end_of_frame, input overrun,
                   output ready);
endinterface

FILE: hdl/ufb_csum.sv
// IPv4 header checksum over the fixed fields, total length and addresses.
module ufb_csum import ufb_pkg::*; (
   input  addr_cfg_type      cfg,
   input  logic [LEN_W-1:0]  ip_len,
   output logic [CSUM_W-1:0] csum
);
   logic [19:0] sum;
   logic [16:0] fold1;
   logic [15:0] fold2;

   // Sum of 16-bit words; ID, TOS and checksum words are zero
   assign sum = 20'({IP_VER_IHL, 8'h00}) + 20'(ip_len) + 20'(IP_FLAGS_DF)
              + 20'({IP_TTL, IP_PROTO_UDP})
              + 20'(cfg.src_ip[31:16]) + 20'(cfg.src_ip[15:0])
              + 20'(cfg.dest_ip[31:16]) + 20'(cfg.dest_ip[15:0]);

   // Two end-around carry folds are enough for eight words
   assign fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
   assign fold2 = fold1[15:0] + 16'(fold1[16]);
   assign csum  = ~fold2;
endmodule

FILE: hdl/ufb_hdr_sel.sv
// Header byte mux: picks the wire-order header byte at a given position.
module ufb_hdr_sel import ufb_pkg::*; (
   input  logic [HDR_IDX_W-1:0] idx,
   input  addr_cfg_type         cfg,
   input  logic [LEN_W-1:0]     ip_len,
   input  logic [LEN_W-1:0]     udp_len,
   input  logic [CSUM_W-1:0]    csum,
   output logic [7:0]           hdr_byte
);
   always_comb begin
      unique case (idx) inside
         // Ethernet: broadcast destination, source MAC, EtherType
         [6'd0:6'd5]: hdr_byte = BCAST_BYTE;
         6'd6:  hdr_byte = cfg.src_mac[47:40];
         6'd7:  hdr_byte = cfg.src_mac[39:32];
         6'd8:  hdr_byte = cfg.src_mac[31:24];
         6'd9:  hdr_byte = cfg.src_mac[23:16];
         6'd10: hdr_byte = cfg.src_mac[15:8];
         6'd11: hdr_byte = cfg.src_mac[7:0];
         6'd12: hdr_byte = ETHERTYPE_IPV4[15:8];
         6'd13: hdr_byte = ETHERTYPE_IPV4[7:0];
         // IPv4 header
         6'd14: hdr_byte = IP_VER_IHL;
         6'd16: hdr_byte = ip_len[15:8];
         6'd17: hdr_byte = ip_len[7:0];
         6'd20: hdr_byte = IP_FLAGS_DF[15:8];
         6'd21: hdr_byte = IP_FLAGS_DF[7:0];
         6'd22: hdr_byte = IP_TTL;
         6'd23: hdr_byte = IP_PROTO_UDP;
         6'd24: hdr_byte = csum[15:8];
         6'd25: hdr_byte = csum[7:0];
         6'd26: hdr_byte = cfg.src_ip[31:24];
         6'd27: hdr_byte = cfg.src_ip[23:16];
         6'd28: hdr_byte = cfg.src_ip[15:8];
         6'd29: hdr_byte = cfg.src_ip[7:0];
         6'd30: hdr_byte = cfg.dest_ip[31:24];
         6'd31: hdr_byte = cfg.dest_ip[23:16];
         6'd32: hdr_byte = cfg.dest_ip[15:8];
         6'd33: hdr_byte = cfg.dest_ip[7:0];
         // UDP header, checksum left zero
         6'd34: hdr_byte = cfg.sport[15:8];
         6'd35: hdr_byte = cfg.sport[7:0];
         6'd36: hdr_byte = cfg.dport[15:8];
         6'd37: hdr_byte = cfg.dport[7:0];
         6'd38: hdr_byte = udp_len[15:8];
         6'd39: hdr_byte = udp_len[7:0];
         // TOS, ID, UDP checksum and unused codes
         default: hdr_byte = 8'h00;
      endcase
   end
endmodule

FILE: hdl/udp_ipv4_frame_builder_unit.sv
// Top level of the UDP/IPv4 frame builder: request stage, sequencer, response register.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-------------------------------------------
//  req_if   | in  | valid/ready    | op, data_len[15:0], payload_byte[7:0]
//  rsp_if   | out | valid/ready    | out_byte[7:0], end_of_frame, overrun
//  csr_*    | in  | csr_we         | csr_index[2:0], csr_wdata[47:0]
//
// A payload request yields one response byte per cycle while the response side
// is not stalled; a start request holds the request stage while the header counter
// walks the 42 header bytes. The first response byte passes through the request
// stage, then the response register.
// Reset clears the configuration, valid flags, header counter and frame state.
// A stalled response keeps its byte; the request stage refills in the same cycle
// that its last byte moves to the response register.
module udp_ipv4_frame_builder_unit import ufb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ufb_req_if.sink               req_if,
   ufb_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_BYTES - 1);

   addr_cfg_type cfg_ff;

   logic                 stg_valid_ff;
   op_type               stg_op_ff;
   logic [LEN_W-1:0]     stg_len_ff;
   logic [7:0]           stg_byte_ff;
   logic [LEN_W-1:0]     len_sat_in;

   logic [HDR_IDX_W-1:0] hdr_idx_ff;
   logic [CSUM_W-1:0]    csum_ff;
   logic [CSUM_W-1:0]    csum_in;
   logic [LEN_W-1:0]     bytes_left_ff;
   logic                 frame_open_ff;

   logic                 out_valid_ff;
   logic [7:0]           out_byte_ff;
   logic                 out_eof_ff;
   logic                 out_ovr_ff;

   logic                 out_free;
   logic                 fire;
   logic                 hdr_end;
   logic                 stg_done;
   logic                 req_take;
   logic [LEN_W-1:0]     ip_len;
   logic [LEN_W-1:0]     udp_len;
   logic [7:0]           hdr_byte;
   logic                 stray;
   logic [LEN_W-1:0]     left_dec;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_SRC_MAC:   cfg_ff.src_mac   <= csr_wdata[MAC_W-1:0];
            CSR_SRC_IP:    cfg_ff.src_ip    <= csr_wdata[IP_W-1:0];
            CSR_DEST_IP:   cfg_ff.dest_ip   <= csr_wdata[IP_W-1:0];
            CSR_SPORT:     cfg_ff.sport     <= csr_wdata[PORT_W-1:0];
            CSR_DPORT:     cfg_ff.dport     <= csr_wdata[PORT_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake control
   assign out_free = !out_valid_ff || rsp_if.ready;
   assign fire     = stg_valid_ff && out_free;
   assign hdr_end  = (hdr_idx_ff == HDR_LAST);
   assign stg_done = fire && ((stg_op_ff == OP_DATA) || hdr_end);
   assign req_take = req_if.valid && req_if.ready;
   assign req_if.ready = !stg_valid_ff || stg_done;

   // Request stage; length saturated so the IPv4 total length fits
   assign len_sat_in = (req_if.data_len > MAX_PAYLOAD) ? MAX_PAYLOAD : req_if.data_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (req_take) begin
         stg_valid_ff <= 1'b1;
      end else if (stg_done) begin
         stg_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_op_ff   <= op_type'(req_if.op);
         stg_len_ff  <= len_sat_in;
         stg_byte_ff <= req_if.payload_byte;
      end
   end

   // Header lengths and checksum
   assign ip_len  = stg_len_ff + IP_OVERHEAD;
   assign udp_len = stg_len_ff + UDP_OVERHEAD;

   ufb_csum u_csum (
      .cfg    (cfg_ff),
      .ip_len (ip_len),
      .csum   (csum_in)
   );

   // Checksum is latched while the first broadcast byte goes out
   always_ff @(posedge clock) begin
      if (fire && (stg_op_ff == OP_START) && (hdr_idx_ff == '0)) begin
         csum_ff <= csum_in;
      end
   end

   ufb_hdr_sel u_hdr_sel (
      .idx      (hdr_idx_ff),
      .cfg      (cfg_ff),
      .ip_len   (ip_len),
      .udp_len  (udp_len),
      .csum     (csum_ff),
      .hdr_byte (hdr_byte)
   );

   // Header counter
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_idx_ff <= '0;
      end else if (fire && (stg_op_ff == OP_START)) begin
         hdr_idx_ff <= hdr_end ? '0 : hdr_idx_ff + 1'b1;
      end
   end

   // Frame state
   assign stray    = !frame_open_ff || (bytes_left_ff == '0);
   assign left_dec = bytes_left_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
         frame_open_ff <= 1'b0;
      end else if (fire) begin
         if (stg_op_ff == OP_START) begin
            if (hdr_end) begin
               bytes_left_ff <= stg_len_ff;
               frame_open_ff <= (stg_len_ff != '0);
            end
         end else if (!stray) begin
            bytes_left_ff <= left_dec;
            frame_open_ff <= (left_dec != '0);
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         if (stg_op_ff == OP_START) begin
            out_byte_ff <= hdr_byte;
            out_eof_ff  <= hdr_end && (stg_len_ff == '0);
            out_ovr_ff  <= 1'b0;
         end else if (stray) begin
            out_byte_ff <= 8'h00;
            out_eof_ff  <= 1'b0;
            out_ovr_ff  <= 1'b1;
         end else begin
            out_byte_ff <= stg_byte_ff;
            out_eof_ff  <= (left_dec == '0);
            out_ovr_ff  <= 1'b0;
         end
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.out_byte     = out_byte_ff;
   assign rsp_if.end_of_frame = out_eof_ff;
   assign rsp_if.overrun      = out_ovr_ff;

   // Checks
   a_ovr_clean: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ovr_ff) |-> (out_byte_ff == 8'h00) && !out_eof_ff)
      else $error("overrun response carries data or end of frame");

   a_hdr_owner: assert property (@(posedge clock) disable iff (reset)
      (hdr_idx_ff != '0) |-> (stg_valid_ff && (stg_op_ff == OP_START)))
      else $error("header counter running without a start request");

   a_hdr_range: assert property (@(posedge clock) disable iff (reset)
      hdr_idx_ff <= HDR_LAST)
      else $error("header counter past last header byte");

   a_open_count: assert property (@(posedge clock) disable iff (reset)
      frame_open_ff == (bytes_left_ff != '0))
      else $error("frame open flag disagrees with byte count");

   a_hdr_hold: assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff && (stg_op_ff == OP_START) && !hdr_end) |=> stg_valid_ff)
      else $error("start request left the stage before its header finished");
endmodule

FILE: test/ufb_frame_monitor.sv
// Frame monitor: predicts every response byte of the frame builder and checks it.
module ufb_frame_monitor import ufb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_op,
   input  logic [LEN_W-1:0]      req_data_len,
   input  logic [7:0]            req_payload_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [7:0]            rsp_out_byte,
   input  logic                  rsp_end_of_frame,
   input  logic                  rsp_overrun,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data;
      logic       eof;
      logic       ovr;
   } wire_byte_type;

   wire_byte_type    expected_bytes[$];
   addr_cfg_type     link_cfg = '0;
   logic [LEN_W-1:0] bytes_left = '0;
   logic             frame_open = 1'b0;
   int               errors = 0;
   int               seen = 0;

   logic [LEN_W-1:0]      frame_len;
   logic [HDR_BYTES*8-1:0] hdr;
   wire_byte_type         got;
   wire_byte_type         want;

   // Ones' complement sum over the ten IPv4 header words, checksum word as zero
   function automatic logic [CSUM_W-1:0] ip_header_checksum(input logic [LEN_W-1:0] total_len);
      logic [31:0] acc;
      acc = {IP_VER_IHL, 8'h00} + total_len + 16'h0000 + IP_FLAGS_DF
          + {IP_TTL, IP_PROTO_UDP}
          + link_cfg.src_ip[31:16] + link_cfg.src_ip[15:0]
          + link_cfg.dest_ip[31:16] + link_cfg.dest_ip[15:0];
      while (acc[31:16] != 16'h0000)
         acc = acc[15:0] + acc[31:16];
      return ~acc[15:0];
   endfunction

   // Full 42-byte header, first wire byte in the top bits
   function automatic logic [HDR_BYTES*8-1:0] frame_header(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] ip_len;
      logic [LEN_W-1:0] udp_len;
      ip_len  = IP_OVERHEAD + len;
      udp_len = UDP_OVERHEAD + len;
      return {{6{BCAST_BYTE}}, link_cfg.src_mac, ETHERTYPE_IPV4,
              IP_VER_IHL, 8'h00, ip_len, 16'h0000, IP_FLAGS_DF,
              IP_TTL, IP_PROTO_UDP, ip_header_checksum(ip_len),
              link_cfg.src_ip, link_cfg.dest_ip,
              link_cfg.sport, link_cfg.dport, udp_len, 16'h0000};
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_SRC_MAC:   link_cfg.src_mac   = csr_wdata[MAC_W-1:0];
               CSR_SRC_IP:    link_cfg.src_ip    = csr_wdata[IP_W-1:0];
               CSR_DEST_IP:   link_cfg.dest_ip   = csr_wdata[IP_W-1:0];
               CSR_SPORT:     link_cfg.sport     = csr_wdata[PORT_W-1:0];
               CSR_DPORT:     link_cfg.dport     = csr_wdata[PORT_W-1:0];
               default: ;
            endcase
         end

         // compare each delivered byte with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_byte, rsp_end_of_frame, rsp_overrun};
            if (expected_bytes.size() == 0) begin
               errors++;
               $display("%0t: unexpected response byte=%02h eof=%b ovr=%b",
                        $time, got.data, got.eof, got.ovr);
            end else begin
               want = expected_bytes.pop_front();
               if (got.data !== want.data || got.eof !== want.eof || got.ovr !== want.ovr) begin
                  errors++;
                  $display("%0t: response %0d expected byte=%02h eof=%b ovr=%b, got byte=%02h eof=%b ovr=%b",
                           $time, seen, want.data, want.eof, want.ovr,
                           got.data, got.eof, got.ovr);
               end
            end
            seen++;
         end

         // predict the bytes of each accepted request
         if (req_valid && req_ready) begin
            if (req_op == OP_DATA) begin
               if (!frame_open || bytes_left == '0) begin
                  // stray byte: flagged, state untouched
                  expected_bytes.push_back({8'h00, 1'b0, 1'b1});
               end else begin
                  bytes_left = bytes_left - 1'b1;
                  if (bytes_left == '0)
                     frame_open = 1'b0;
                  expected_bytes.push_back({req_payload_byte, bytes_left == '0, 1'b0});
               end
            end else begin
               // start: saturate length, emit header, open the new frame
               frame_len = (req_data_len > MAX_PAYLOAD) ? MAX_PAYLOAD : req_data_len;
               hdr = frame_header(frame_len);
               for (int i = 0; i < HDR_BYTES; i++)
                  expected_bytes.push_back({hdr[8*(HDR_BYTES-1-i) +: 8],
                                            (frame_len == '0) && (i == HDR_BYTES-1), 1'b0});
               bytes_left = frame_len;
               frame_open = (frame_len != '0);
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_bytes.size();
   end

endmodule

FILE: test/udp_ipv4_frame_builder_unit_tb.sv
// Testbench top: clock, reset, request and register stimulus, response stalls, verdict.
module udp_ipv4_frame_builder_unit_tb import ufb_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 95;
   localparam int RANDOM_PHASES = 4;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatches;
   int pending;
   int sent_items = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   bit quiet = 1'b0;
   bit hold_request = 1'b0;

   ufb_req_if req_bus ();
   ufb_rsp_if rsp_bus ();

   udp_ipv4_frame_builder_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ufb_frame_monitor u_monitor (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_bus.valid),
      .req_ready        (req_bus.ready),
      .req_op           (req_bus.op),
      .req_data_len     (req_bus.data_len),
      .req_payload_byte (req_bus.payload_byte),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_out_byte     (rsp_bus.out_byte),
      .rsp_end_of_frame (rsp_bus.end_of_frame),
      .rsp_overrun      (rsp_bus.overrun),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatches),
      .pending_count    (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("udp_ipv4_frame_builder_unit: mismatch");
         $finish;
      end
   end

   // Response side: random stalls, plus one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= 6);
         end
      end
   end

   // Offer one request and wait for its handshake
   task automatic send_item(input op_type op, input logic [LEN_W-1:0] len,
                            input logic [7:0] data);
      while (!quiet && $urandom_range(0, 99) < 6) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.op           <= op;
      req_bus.data_len     <= len;
      req_bus.payload_byte <= data;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      sent_items++;
   endtask

   // Start a frame, then send n payload bytes (fewer than the length truncates it)
   task automatic send_frame(input logic [LEN_W-1:0] len, input int n_bytes);
      send_item(OP_START, len, 8'($urandom));
      repeat (n_bytes)
         send_item(OP_DATA, LEN_W'($urandom), 8'($urandom));
   endtask

   // Stop offering and wait until every predicted byte has been delivered
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Reprogram all addressing registers once the block has gone quiet
   task automatic configure(input logic [MAC_W-1:0] mac, input logic [IP_W-1:0] sip,
                            input logic [IP_W-1:0] dip, input logic [PORT_W-1:0] sport,
                            input logic [PORT_W-1:0] dport);
      drain();
      repeat (4) @(posedge clock);
      // upper data bits beyond each register are random and must be dropped
      write_reg(CSR_SRC_MAC, mac);
      write_reg(CSR_SRC_IP, {16'($urandom), sip});
      write_reg(CSR_DEST_IP, {16'($urandom), dip});
      write_reg(CSR_SPORT, {32'($urandom), sport});
      write_reg(CSR_DPORT, {32'($urandom), dport});
      // unused indexes must not disturb anything
      for (int k = CSR_DPORT + 1; k < 2**CSR_IDX_W; k++)
         write_reg(CSR_IDX_W'(k), CSR_DATA_W'({$urandom, $urandom}));
      csr_we <= 1'b0;
   endtask

   // Mostly complete frames with random content; some truncated, oversize or stray
   task automatic run_random(input int target);
      int first;
      int pick;
      int len;
      first = sent_items;
      while (sent_items - first < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) : $urandom_range(7, 40);
            send_frame(LEN_W'(len), len);
         end else if (pick < 85) begin
            len = $urandom_range(2, 12);
            send_frame(LEN_W'(len), $urandom_range(0, len - 1));
         end else if (pick < 92) begin
            send_frame(LEN_W'($urandom_range(65000, 65535)), $urandom_range(0, 4));
         end else begin
            repeat ($urandom_range(1, 3))
               send_item(OP_DATA, LEN_W'($urandom), 8'($urandom));
         end
         if ($urandom_range(0, 99) < 3)
            drain();
      end
   endtask

   initial begin
      req_bus.valid        <= 1'b0;
      req_bus.op           <= OP_START;
      req_bus.data_len     <= '0;
      req_bus.payload_byte <= '0;
      csr_we               <= 1'b0;
      csr_index            <= CSR_SRC_MAC;
      csr_wdata            <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty payload and a stray byte on the reset configuration
      send_frame(16'd0, 0);
      send_item(OP_DATA, 16'hFFFF, 8'hFF);

      // directed: all-ones addressing, full frame then one byte too many
      configure('1, '1, '1, '1, '1);
      send_item(OP_START, 16'd3, 8'hFF);
      send_item(OP_DATA, 16'h0000, 8'h00);
      send_item(OP_DATA, 16'hFFFF, 8'hFF);
      send_item(OP_DATA, 16'h5A5A, 8'h5A);
      send_item(OP_DATA, 16'hA5A5, 8'hA5);

      // directed: saturated lengths and a start while a frame is open
      send_frame(16'hFFFF, 2);
      send_frame(16'd1, 1);
      send_frame(16'd65508, 1);
      send_frame(MAX_PAYLOAD, 0);
      send_frame(16'd1, 1);

      configure(48'h0123_4567_89AB, 32'hC0A8_0001, 32'h0A00_00FE, 16'h1234, 16'h0050);
      send_frame(16'd0, 0);
      send_frame(16'd2, 2);

      // random phases under changing configurations
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            1:       configure('0, '0, '0, '0, '0);
            3:       configure('1, '1, '1, '1, '1);
            default: configure(MAC_W'({$urandom, $urandom}), $urandom, $urandom,
                               PORT_W'($urandom), PORT_W'($urandom));
         endcase
         // long response hold-off so the request side backs up
         if (p == 0)
            hold_request = 1'b1;
         quiet = (p == 2);
         run_random(PHASE_ITEMS);
      end
      quiet = 1'b0;

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("udp_ipv4_frame_builder_unit: match");
      else
         $display("udp_ipv4_frame_builder_unit: mismatch");
      $finish;
   end

endmodule
